// ----- rtl/matrix_multiply_macros.svh -----
// Assertion macros used by the checker of the matrix multiply block.
`ifndef MATRIX_MULTIPLY_MACROS_SVH
`define MATRIX_MULTIPLY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("matrix_multiply: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("matrix_multiply: next-cycle check failed");

`endif

// ----- rtl/mm_pkg.sv -----
package mm_pkg;

   localparam int MAX_DIM_DEF    = 8;
   localparam int DATA_WIDTH_DEF = 16;

   localparam int IDX_W     = 3;
   localparam int DIM_W     = 4;
   localparam int VAL_W     = 16;
   localparam int RES_W     = 35;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      REQ_LOAD_A  = 2'd0,
      REQ_LOAD_B  = 2'd1,
      REQ_COMPUTE = 2'd2
   } req_code_type;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COL_COUNT  = 2'd2;

   typedef struct packed {
      logic [1:0]              req_type;
      logic [IDX_W-1:0]        elem_row;
      logic [IDX_W-1:0]        elem_col;
      logic signed [VAL_W-1:0] elem_value;
   } req_type_type;

   typedef struct packed {
      logic signed [RES_W-1:0] result_value;
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic                    last;
   } rsp_type_type;

endpackage

// ----- rtl/matrix_multiply.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_data  (load A, load B or compute)
// rsp      out        rsp_valid/rsp_ready    rsp_data  (one product element)
// csr      in         csr_valid/csr_ready    csr_index, csr_wdata (dimension registers)
//
// A load transaction is accepted every cycle while no compute runs.
// For a compute transaction, each element issues one read of A and one of B per inner index,
// then waits while the read and product registers drain into the accumulator and loads the result.
// req_ready stays low for the whole run; a stalled rsp channel holds the sequencer before the
// next element, and the final result may wait while new transactions are already accepted.
// Synchronous reset sets the dimension registers to MAX_DIM; element memories are not cleared.
module matrix_multiply #(
   parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
   parameter int DATA_WIDTH = mm_pkg::DATA_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  mm_pkg::req_type_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output mm_pkg::rsp_type_type           rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mm_pkg::DIM_W-1:0]       csr_wdata
);
   import mm_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LIN_W  = 2 * IDX_W;
   localparam int PROD_W = 2 * DATA_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_RUN    = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      r = d;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (d > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   state_type state_ff, state_in;

   logic [DIM_W-1:0] row_count_ff, row_count_in;
   logic [DIM_W-1:0] inner_size_ff, inner_size_in;
   logic [DIM_W-1:0] col_count_ff, col_count_in;

   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IDX_W-1:0] i_last, j_last, k_last;
   logic             issue, rsp_load, last_elem, out_free;

   logic signed [DATA_WIDTH-1:0] a_mem [DEPTH];
   logic signed [DATA_WIDTH-1:0] b_mem [DEPTH];
   logic signed [DATA_WIDTH-1:0] a_rd_ff, b_rd_ff;
   logic                         rd_vld_ff, prod_vld_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [RES_W-1:0]      acc_ff, acc_in;

   logic                         req_fire, in_range, we_a, we_b;
   logic [LIN_W-1:0]             wr_lin, a_lin, b_lin;
   logic [ADDR_W-1:0]            wr_addr, a_addr, b_addr;
   logic signed [DATA_WIDTH-1:0] wr_val;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type_type rsp_data_ff, rsp_data_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Load path: out-of-range coordinates are dropped.
   assign in_range = ({1'b0, req_data.elem_row} < DIM_W'(MAX_DIM)) &&
                     ({1'b0, req_data.elem_col} < DIM_W'(MAX_DIM));
   assign we_a     = req_fire && in_range && (req_data.req_type == REQ_LOAD_A);
   assign we_b     = req_fire && in_range && (req_data.req_type == REQ_LOAD_B);
   assign wr_lin   = LIN_W'(req_data.elem_row) * LIN_W'(MAX_DIM) + LIN_W'(req_data.elem_col);
   assign wr_addr  = wr_lin[ADDR_W-1:0];
   assign wr_val   = DATA_WIDTH'(req_data.elem_value);

   // A is walked along row i, B down column j.
   assign a_lin  = LIN_W'(i_ff) * LIN_W'(MAX_DIM) + LIN_W'(k_ff);
   assign b_lin  = LIN_W'(k_ff) * LIN_W'(MAX_DIM) + LIN_W'(j_ff);
   assign a_addr = a_lin[ADDR_W-1:0];
   assign b_addr = b_lin[ADDR_W-1:0];

   assign i_last    = IDX_W'(clamp_dim(row_count_ff) - DIM_W'(1));
   assign k_last    = IDX_W'(clamp_dim(inner_size_ff) - DIM_W'(1));
   assign j_last    = IDX_W'(clamp_dim(col_count_ff) - DIM_W'(1));
   assign last_elem = (i_ff == i_last) && (j_ff == j_last);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      issue    = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.req_type == REQ_COMPUTE)) begin
               state_in = ST_RUN;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            issue = 1'b1;
            if (k_ff == k_last) begin
               k_in     = '0;
               state_in = ST_FINISH;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_FINISH: begin
            // Wait for the multiply pipeline to drain and the output register to free up.
            if (!rd_vld_ff && !prod_vld_ff && out_free) begin
               rsp_load = 1'b1;
               if (last_elem) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RUN;
                  if (j_ff == j_last) begin
                     j_in = '0;
                     i_in = i_ff + IDX_W'(1);
                  end else begin
                     j_in = j_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (issue && (k_ff == '0)) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + RES_W'(prod_ff);
      end
   end

   always_comb begin
      row_count_in  = row_count_ff;
      inner_size_in = inner_size_ff;
      col_count_in  = col_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ROW_COUNT:  row_count_in  = csr_wdata;
            REG_INNER_SIZE: inner_size_in = csr_wdata;
            REG_COL_COUNT:  col_count_in  = csr_wdata;
            default:        ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.result_value = acc_ff;
         rsp_data_in.out_row      = i_ff;
         rsp_data_in.out_col      = j_ff;
         rsp_data_in.last         = last_elem;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we_a) begin
         a_mem[wr_addr] <= wr_val;
      end
      a_rd_ff <= a_mem[a_addr];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         b_mem[wr_addr] <= wr_val;
      end
      b_rd_ff <= b_mem[b_addr];
   end

   always_ff @(posedge clock) begin
      prod_ff     <= a_rd_ff * b_rd_ff;
      acc_ff      <= acc_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_vld_ff     <= 1'b0;
         prod_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         row_count_ff  <= DIM_W'(MAX_DIM);
         inner_size_ff <= DIM_W'(MAX_DIM);
         col_count_ff  <= DIM_W'(MAX_DIM);
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= issue;
         prod_vld_ff   <= rd_vld_ff;
         rsp_valid_ff  <= rsp_valid_in;
         row_count_ff  <= row_count_in;
         inner_size_ff <= inner_size_in;
         col_count_ff  <= col_count_in;
      end
   end

endmodule

// ----- rtl/mm_checker.sv -----
`include "matrix_multiply_macros.svh"

module mm_checker #(
   parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input mm_pkg::req_type_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input mm_pkg::rsp_type_type rsp_data
);
   import mm_pkg::*;

   // A waiting result transaction must hold still until it is taken.
   `MM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Result coordinates never leave the storage grid.
   `MM_ASSERT_SAME(a_rsp_coord, clock, reset, rsp_valid, (rsp_data.out_row <= IDX_W'(MAX_DIM - 1)) && (rsp_data.out_col <= IDX_W'(MAX_DIM - 1)))

   // A compute transaction blocks further requests while it runs.
   `MM_ASSERT_NEXT(a_compute_busy, clock, reset, req_valid && req_ready && (req_data.req_type == REQ_COMPUTE), !req_ready)

   // Reset leaves no result pending.
   `MM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind matrix_multiply mm_checker #(.MAX_DIM(MAX_DIM)) u_mm_checker (.*);

// ----- verif/mm_product_checker.sv -----
module mm_product_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  mm_pkg::req_type_type         req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  mm_pkg::rsp_type_type         rsp_data,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [mm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mm_pkg::DIM_W-1:0]     csr_wdata,
   output int                           fail_count,
   output int                           pending
);
   import mm_pkg::*;

   localparam int GRID = MAX_DIM_DEF;

   logic signed [VAL_W-1:0] a_elems [GRID*GRID];
   logic signed [VAL_W-1:0] b_elems [GRID*GRID];
   logic [DIM_W-1:0]        rows_reg;
   logic [DIM_W-1:0]        inner_reg;
   logic [DIM_W-1:0]        cols_reg;
   rsp_type_type            awaited_products [$];

   // A register value of zero acts as one, and anything above the grid size as the grid size.
   function automatic int dim_used(logic [DIM_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > GRID) return GRID;
      return int'(raw);
   endfunction

   task automatic report(string msg);
      $display("[%0t] product check: %s", $time, msg);
      fail_count++;
   endtask

   task automatic queue_products();
      int           nr;
      int           nk;
      int           nc;
      longint       acc;
      rsp_type_type item;
      nr = dim_used(rows_reg);
      nk = dim_used(inner_reg);
      nc = dim_used(cols_reg);
      for (int i = 0; i < nr; i++) begin
         for (int j = 0; j < nc; j++) begin
            acc = 0;
            for (int k = 0; k < nk; k++) begin
               acc += longint'(a_elems[i*GRID + k]) * longint'(b_elems[k*GRID + j]);
            end
            item.result_value = acc[RES_W-1:0];
            item.out_row = i[IDX_W-1:0];
            item.out_col = j[IDX_W-1:0];
            item.last = (i == nr - 1) && (j == nc - 1);
            awaited_products.push_back(item);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type_type want;
      if (reset) begin
         rows_reg = DIM_W'(GRID);
         inner_reg = DIM_W'(GRID);
         cols_reg = DIM_W'(GRID);
         awaited_products.delete();
         fail_count = 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ROW_COUNT:  rows_reg = csr_wdata;
               REG_INNER_SIZE: inner_reg = csr_wdata;
               REG_COL_COUNT:  cols_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_data.req_type)
               REQ_LOAD_A:  a_elems[{req_data.elem_row, req_data.elem_col}] = req_data.elem_value;
               REQ_LOAD_B:  b_elems[{req_data.elem_row, req_data.elem_col}] = req_data.elem_value;
               REQ_COMPUTE: queue_products();
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_products.size() == 0) begin
               report($sformatf("unexpected result at (%0d,%0d) value %0d",
                  rsp_data.out_row, rsp_data.out_col, rsp_data.result_value));
            end else begin
               want = awaited_products.pop_front();
               if (rsp_data.result_value !== want.result_value)
                  report($sformatf("result_value at (%0d,%0d): got %0d, expected %0d",
                     want.out_row, want.out_col, rsp_data.result_value, want.result_value));
               if (rsp_data.out_row !== want.out_row)
                  report($sformatf("out_row: got %0d, expected %0d",
                     rsp_data.out_row, want.out_row));
               if (rsp_data.out_col !== want.out_col)
                  report($sformatf("out_col: got %0d, expected %0d",
                     rsp_data.out_col, want.out_col));
               if (rsp_data.last !== want.last)
                  report($sformatf("last at (%0d,%0d): got %0b, expected %0b",
                     want.out_row, want.out_col, rsp_data.last, want.last));
            end
         end
         pending <= awaited_products.size();
      end
   end

endmodule

// ----- verif/tb_matrix_multiply.sv -----
module tb_matrix_multiply;
   import mm_pkg::*;

   localparam int                   GRID         = MAX_DIM_DEF;
   localparam int                   RANDOM_ITEMS = 250;
   localparam int                   DRAIN_CYCLES = 8;
   localparam logic [1:0]           REQ_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type_type         req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_wdata = '0;

   int fail_count;
   int pending;
   bit calm = 1'b0;
   bit a_loaded [GRID*GRID];
   bit b_loaded [GRID*GRID];
   int rows = GRID;
   int inner = GRID;
   int cols = GRID;
   int items_sent = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   matrix_multiply dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mm_product_checker product_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 23);
   end

   function automatic int dim_of(logic [DIM_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > GRID) return GRID;
      return int'(raw);
   endfunction

   // Dimensions at the ends of the range are often written as their out-of-range aliases.
   function automatic logic [DIM_W-1:0] raw_for(int d);
      if (d == 1 && $urandom_range(2) == 0) return '0;
      if (d == GRID && $urandom_range(1) == 0) return DIM_W'($urandom_range(GRID + 1, 15));
      return DIM_W'(d);
   endfunction

   function automatic logic [VAL_W-1:0] rand_value();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'hFFFF;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // Valid is left high after acceptance; it only drops when a gap is taken or the bench settles.
   task automatic send(input logic [1:0] code, input logic [IDX_W-1:0] r,
                       input logic [IDX_W-1:0] c, input logic [VAL_W-1:0] v);
      req_type_type item;
      item.req_type = code;
      item.elem_row = r;
      item.elem_col = c;
      item.elem_value = v;
      if (!calm && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      if (code != REQ_UNUSED) items_sent++;
      if (code == REQ_LOAD_A) a_loaded[{r, c}] = 1'b1;
      if (code == REQ_LOAD_B) b_loaded[{r, c}] = 1'b1;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_dims(input logic [DIM_W-1:0] raw_r, input logic [DIM_W-1:0] raw_i,
                           input logic [DIM_W-1:0] raw_c);
      rows = dim_of(raw_r);
      inner = dim_of(raw_i);
      cols = dim_of(raw_c);
      csr_write(REG_ROW_COUNT, raw_r);
      csr_write(REG_INNER_SIZE, raw_i);
      csr_write(REG_COL_COUNT, raw_c);
      if ($urandom_range(3) == 0) csr_write(REG_UNMAPPED, DIM_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Hold off new transactions until every product has come back and the block is idle.
   task automatic settle(input int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (extra) @(posedge clock);
   endtask

   // Loads every operand element that the current shape reads and has never been written.
   task automatic fill_operands();
      for (int i = 0; i < rows; i++)
         for (int k = 0; k < inner; k++)
            if (!a_loaded[i*GRID + k]) send(REQ_LOAD_A, i[2:0], k[2:0], rand_value());
      for (int k = 0; k < inner; k++)
         for (int j = 0; j < cols; j++)
            if (!b_loaded[k*GRID + j]) send(REQ_LOAD_B, k[2:0], j[2:0], rand_value());
   endtask

   task automatic random_load_in_shape();
      if ($urandom_range(1) == 0)
         send(REQ_LOAD_A, 3'($urandom_range(rows - 1)), 3'($urandom_range(inner - 1)),
              rand_value());
      else
         send(REQ_LOAD_B, 3'($urandom_range(inner - 1)), 3'($urandom_range(cols - 1)),
              rand_value());
   endtask

   initial begin
      int phase;
      int d_r;
      int d_i;
      int d_c;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Small product with the extreme element values.
      set_dims(4'd2, 4'd2, 4'd2);
      send(REQ_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
      send(REQ_LOAD_A, 3'd0, 3'd1, 16'h8000);
      send(REQ_LOAD_A, 3'd1, 3'd0, 16'hFFFF);
      send(REQ_LOAD_A, 3'd1, 3'd1, 16'h0001);
      send(REQ_LOAD_B, 3'd0, 3'd0, 16'h8000);
      send(REQ_LOAD_B, 3'd0, 3'd1, 16'h7FFF);
      send(REQ_LOAD_B, 3'd1, 3'd0, 16'h8000);
      send(REQ_LOAD_B, 3'd1, 3'd1, 16'h0000);
      send(REQ_COMPUTE, 3'd7, 3'd7, 16'hFFFF);
      send(REQ_UNUSED, 3'd5, 3'd2, 16'h5A5A);
      settle(DRAIN_CYCLES);

      // Zero rows and columns act as one and an oversized inner size as eight, so this
      // gives the largest positive sum: eight products of the most negative element.
      set_dims(4'd0, 4'd15, 4'd0);
      for (int k = 0; k < GRID; k++) begin
         send(REQ_LOAD_A, 3'd0, k[2:0], 16'h8000);
         send(REQ_LOAD_B, k[2:0], 3'd0, 16'h8000);
      end
      send(REQ_COMPUTE, 3'd0, 3'd0, 16'h0000);
      send(REQ_LOAD_A, 3'd7, 3'd7, 16'h7FFF);
      send(REQ_LOAD_B, 3'd7, 3'd7, 16'hFFFF);

      items_sent = 0;
      phase = 0;
      while (items_sent < RANDOM_ITEMS) begin
         settle(DRAIN_CYCLES);
         calm = (phase >= 3 && phase < 6);
         if ($urandom_range(9) == 0) begin
            d_r = GRID;
            d_i = GRID;
            d_c = GRID;
         end else begin
            d_r = ($urandom_range(4) == 0) ? $urandom_range(5, GRID) : $urandom_range(1, 3);
            d_i = ($urandom_range(4) == 0) ? $urandom_range(5, GRID) : $urandom_range(1, 3);
            d_c = ($urandom_range(4) == 0) ? $urandom_range(5, GRID) : $urandom_range(1, 3);
         end
         set_dims(raw_for(d_r), raw_for(d_i), raw_for(d_c));
         repeat ($urandom_range(2, 5)) begin
            case ($urandom_range(9))
               0: send(REQ_UNUSED, 3'($urandom), 3'($urandom), rand_value());
               1: send($urandom_range(1) ? REQ_LOAD_B : REQ_LOAD_A, 3'($urandom),
                       3'($urandom), rand_value());
               default: begin
                  repeat ($urandom_range(0, 4)) random_load_in_shape();
                  fill_operands();
                  send(REQ_COMPUTE, 3'($urandom), 3'($urandom), rand_value());
               end
            endcase
         end
         phase++;
      end

      settle(20);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
